@@ sv/pfte_pkg.sv @@
// ----------------------------------------------------------------------------
// pfte_pkg
// Shared constants, payload types and result helpers for the page frame
// table engine.
// ----------------------------------------------------------------------------
package pfte_pkg;

	localparam int ENTRIES    = 1024;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 48;
	localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int FLAG_W     = 16;
	localparam int KIND_W     = 3;
	localparam int WANT_W     = 11;
	localparam int IDX_OUT_W  = 10;
	localparam int STATUS_W   = 2;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int LEN_W      = (CNT_W > WANT_W) ? CNT_W : WANT_W;

	localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIND_PHYS = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FIND_VIRT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MAP       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIND_RUN  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_RUN   = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] map_address;
		logic [FLAG_W-1:0] flag_bits;
		logic [WANT_W-1:0] page_count;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [IDX_OUT_W-1:0] entry_index;
		logic [ADDR_W-1:0]    phys_base;
		logic [ADDR_W-1:0]    virt_base;
		logic [FLAG_W-1:0]    entry_flags;
	} rsp_item_t;

	typedef struct packed {
		logic [PAGE_W-1:0] frame_number;
		logic [PAGE_W-1:0] virtual_page;
		logic [FLAG_W-1:0] frame_flags;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} ctrl_stat_t;

	function automatic rsp_item_t make_hit(input logic [IDX_W-1:0] idx, input entry_t e);
		rsp_item_t                      r;
		logic [IDX_W+IDX_OUT_W-1:0]     wide;
		wide          = {{IDX_OUT_W{1'b0}}, idx};
		r.status      = ST_OK;
		r.entry_index = wide[IDX_OUT_W-1:0];
		r.phys_base   = {e.frame_number, {PAGE_SHIFT{1'b0}}};
		r.virt_base   = {e.virtual_page, {PAGE_SHIFT{1'b0}}};
		r.entry_flags = e.frame_flags;
		return r;
	endfunction

	function automatic rsp_item_t make_fail(input logic [STATUS_W-1:0] status);
		rsp_item_t r;
		r        = '0;
		r.status = status;
		return r;
	endfunction

endpackage

@@ sv/page_frame_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// page_frame_table_engine_top
// Page frame table with lookup, map and first-fit contiguous run search.
// ----------------------------------------------------------------------------
// One request is worked on at a time. Append, and any request that fails
// without touching the table, has its response set in the done state with
// no scan. Lookups, map and run search scan the table one entry per cycle
// through the single read port of the frame memory, stopping at the first
// hit or at the last filled entry. The next request is taken once the
// response has moved into the output register. No clearing pass follows
// reset: entries are only read below the fill count.
module page_frame_table_engine_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  pfte_pkg::req_item_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output pfte_pkg::rsp_item_t         rsp,
	input  logic                        cfg_we,
	input  logic [pfte_pkg::FLAG_W-1:0] cfg_data
);
	import pfte_pkg::*;

	logic [FLAG_W-1:0] mask_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;
	ctrl_stat_t        stat;
	rsp_item_t         res;
	ram_req_t          ram;
	entry_t            rdata;
	logic              start;
	logic              res_take;

	assign start    = req_valid && stat.idle;
	assign res_take = stat.res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= FLAG_W'(1);
		end else if (cfg_we) begin
			mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	pfte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (req),
		.mask     (mask_q),
		.res_take (res_take),
		.rdata    (rdata),
		.stat     (stat),
		.res      (res),
		.ram      (ram)
	);

	pfte_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	assign req_stall = !stat.idle;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sv/pfte_ram.sv @@
// ----------------------------------------------------------------------------
// pfte_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pfte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/pfte_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfte_ctrl
// Item sequencer: append, table scan for lookups, map write-back and
// first-fit contiguous run search over the frame table memory.
// ----------------------------------------------------------------------------
module pfte_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pfte_pkg::req_item_t        item,
	input  logic [pfte_pkg::FLAG_W-1:0] mask,
	input  logic                       res_take,
	input  pfte_pkg::entry_t           rdata,
	output pfte_pkg::ctrl_stat_t       stat,
	output pfte_pkg::rsp_item_t        res,
	output pfte_pkg::ram_req_t         ram
);
	import pfte_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [KIND_W-1:0] kind_q;
	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] vpage_q;
	logic [FLAG_W-1:0] flags_q;
	logic [LEN_W-1:0]  want_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]  run_idx_q;
	entry_t            run_entry_q;
	logic [PAGE_W-1:0] prev_frame_q;
	rsp_item_t         res_q;

	logic [PAGE_W-1:0] in_page;
	logic              full;
	logic              issue;
	logic              last;
	logic              match;
	logic              used;
	logic              contig;
	logic [LEN_W-1:0]  new_len;
	logic              run_hit;
	logic              hit;
	entry_t            map_entry;
	entry_t            app_entry;
	logic              app_wr;
	logic              map_wr;

	assign in_page = item.address[ADDR_W-1:PAGE_SHIFT];
	assign full    = (count_q == CNT_W'(ENTRIES));
	assign issue   = (state_q == S_SCAN) && (rd_idx_q < count_q);
	assign last    = (CNT_W'(idx_s1) + CNT_W'(1)) == count_q;

	always_comb begin
		unique case (kind_q)
			KIND_FIND_PHYS: match = (rdata.frame_number == page_q);
			KIND_FIND_VIRT: match = (rdata.virtual_page == page_q);
			KIND_MAP:       match = (rdata.frame_number == page_q);
			default:        match = 1'b0;
		endcase
	end

	assign used   = |(rdata.frame_flags & mask);
	assign contig = (len_q != '0) &&
		(({1'b0, prev_frame_q} + {{PAGE_W{1'b0}}, 1'b1}) == {1'b0, rdata.frame_number});
	assign new_len = used ? '0 : (contig ? len_q + LEN_W'(1) : LEN_W'(1));
	assign run_hit = !used && (new_len == want_q);
	assign hit     = (kind_q == KIND_FIND_RUN) ? run_hit : match;

	assign map_entry = '{frame_number: rdata.frame_number, virtual_page: vpage_q,
		frame_flags: flags_q};
	assign app_entry = '{frame_number: in_page, virtual_page: '0, frame_flags: '0};

	assign app_wr = start && (item.kind == KIND_APPEND) && !full;
	assign map_wr = (state_q == S_SCAN) && valid_s1 && (kind_q == KIND_MAP) && match;

	always_comb begin
		ram.we    = app_wr || map_wr;
		ram.waddr = app_wr ? count_q[IDX_W-1:0] : idx_s1;
		ram.wdata = app_wr ? app_entry : map_entry;
		ram.raddr = rd_idx_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			len_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q   <= item.kind;
						page_q   <= in_page;
						vpage_q  <= item.map_address[ADDR_W-1:PAGE_SHIFT];
						flags_q  <= item.flag_bits;
						want_q   <= LEN_W'(item.page_count);
						rd_idx_q <= '0;
						valid_s1 <= 1'b0;
						len_q    <= '0;
						state_q  <= S_DONE;
						unique case (item.kind) inside
							KIND_APPEND: begin
								if (full) begin
									res_q <= make_fail(ST_FULL);
								end else begin
									res_q   <= make_hit(count_q[IDX_W-1:0], app_entry);
									count_q <= count_q + CNT_W'(1);
								end
							end
							KIND_FIND_PHYS, KIND_FIND_VIRT, KIND_MAP: begin
								if (count_q == '0) begin
									res_q <= make_fail(ST_NO_MATCH);
								end else begin
									state_q <= S_SCAN;
								end
							end
							KIND_FIND_RUN: begin
								if (count_q == '0 || item.page_count == '0) begin
									res_q <= make_fail(ST_NO_RUN);
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: res_q <= make_fail(ST_NO_MATCH);
						endcase
					end
				end
				S_SCAN: begin
					valid_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						idx_s1   <= rd_idx_q[IDX_W-1:0];
					end
					if (valid_s1) begin
						prev_frame_q <= rdata.frame_number;
						len_q        <= new_len;
						if (!used && !contig) begin
							run_idx_q   <= idx_s1;
							run_entry_q <= rdata;
						end
						if (hit) begin
							state_q <= S_DONE;
							if (kind_q == KIND_FIND_RUN) begin
								res_q <= contig ? make_hit(run_idx_q, run_entry_q)
									: make_hit(idx_s1, rdata);
							end else if (kind_q == KIND_MAP) begin
								res_q <= make_hit(idx_s1, map_entry);
							end else begin
								res_q <= make_hit(idx_s1, rdata);
							end
						end else if (last) begin
							state_q <= S_DONE;
							res_q   <= make_fail((kind_q == KIND_FIND_RUN) ? ST_NO_RUN
								: ST_NO_MATCH);
						end
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.idle      = (state_q == S_IDLE);
	assign stat.res_valid = (state_q == S_DONE);
	assign res            = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		app_wr |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not advance entry count");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && valid_s1 |-> CNT_W'(idx_s1) < count_q)
		else $error("scan read beyond filled entries");

	a_map_addr: assert property (@(posedge clk) disable iff (!arst_n)
		map_wr |-> !app_wr && CNT_W'(ram.waddr) < count_q)
		else $error("map write outside filled entries");

endmodule
